@@ hdl/mlrq_pkg.sv @@
`timescale 1ns / 1ps
package mlrq_pkg;
  localparam int QueueDepth = 128;
  localparam int NumQueues = 8;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int QW = $clog2(NumQueues);
  localparam int AddrW = PtrW + QW;
  localparam int EntryW = 40;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_STRICT = 2'd1;
  localparam logic [1:0] OP_MINPRI = 2'd2;
  localparam logic [1:0] OP_MINTIME = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADQ = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [15:0] pid;
    logic [7:0] prio;
    logic [15:0] tleft;
  } entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture input word
    logic mem_rd;      // read at rd_addr
    logic [AddrW-1:0] rd_addr;
    logic mem_wr;
    logic [AddrW-1:0] wr_addr;
    logic wr_sel;      // 0: input entry, 1: held head entry
    logic cap_head;    // capture read data as head (and best)
    logic cap_best;    // capture read data as best
    logic out_load;
    logic [1:0] out_status;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic better;      // read data strictly smaller than best
  } sts_t;
endpackage

@@ hdl/mlrq_datapath.sv @@
`timescale 1ns / 1ps
module mlrq_datapath
  import mlrq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic key_time,
  input  logic [15:0] process_id,
  input  logic [7:0] priority_req,
  input  logic [15:0] run_time,
  output sts_t sts,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [15:0] out_process_id,
  output logic [7:0] out_priority,
  output logic [15:0] out_time_left
);
  entry_t mem [NumQueues*QueueDepth];
  entry_t rd_data;
  entry_t in_ent;
  entry_t head_ent;
  entry_t best;
  logic [15:0] kr, kb;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[cmd.wr_addr] <= cmd.wr_sel ? head_ent : in_ent;
    if (cmd.mem_rd) rd_data <= mem[cmd.rd_addr];
  end

  assign kr = key_time ? rd_data.tleft : {8'd0, rd_data.prio};
  assign kb = key_time ? best.tleft : {8'd0, best.prio};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_ent.pid <= process_id;
      in_ent.prio <= priority_req;
      in_ent.tleft <= run_time;
    end
    if (cmd.cap_head) begin
      head_ent <= rd_data;
      best <= rd_data;
    end else if (cmd.cap_best) begin
      best <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      out_process_id <= cmd.out_zero ? 16'd0 : best.pid;
      out_priority <= cmd.out_zero ? 8'd0 : best.prio;
      out_time_left <= cmd.out_zero ? 16'd0 : best.tleft;
    end
  end

  assign sts.out_busy = out_valid && out_stall;
  assign sts.better = kr < kb;
endmodule

@@ hdl/mlrq_controller.sv @@
`timescale 1ns / 1ps
module mlrq_controller
  import mlrq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [3:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] opcode,
  input  logic [2:0] queue_index,
  input  sts_t sts,
  output cmd_t cmd,
  output logic key_time
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_RD_HEAD, S_SCAN, S_LAST, S_SWAP, S_DONE
  } state_t;

  state_t state;
  logic [PtrW-1:0] head [NumQueues];
  logic [PtrW-1:0] tail [NumQueues];
  logic [3:0] qiu;
  logic [1:0] op;
  logic [QW-1:0] q;
  logic [PtrW-1:0] scan, best_idx;
  logic scan_pend;   // read issued last cycle, data to compare now
  logic [3:0] cfg_sat;
  logic [QW-1:0] sq;
  logic sfound;
  logic qbad;
  logic out_load;
  logic [1:0] out_status;
  logic out_zero;

  assign cfg_sat = (cfg_data > 4'(NumQueues)) ? 4'(NumQueues) : cfg_data;
  // hold input when busy, while the result is written or held stalled
  assign in_stall = (state != S_IDLE) || out_load || sts.out_busy;
  assign qbad = {1'b0, queue_index} >= qiu;

  // first non-empty queue in use
  always_comb begin
    sq = '0;
    sfound = 1'b0;
    for (int i = NumQueues - 1; i >= 0; i--) begin
      if (4'(i) < qiu && head[i] != tail[i]) begin
        sq = QW'(i);
        sfound = 1'b1;
      end
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid && !in_stall;
    cmd.out_load = out_load;
    cmd.out_status = out_status;
    cmd.out_zero = out_zero;
    case (state)
      S_DECIDE: begin
        if (op == OP_ENQ) begin
          cmd.mem_wr = (PtrW'(tail[q] + 1'b1) != head[q]);
          cmd.wr_addr = {q, tail[q]};
        end
        cmd.mem_rd = 1'b1;
        cmd.rd_addr = {q, head[q]};
      end
      S_RD_HEAD: cmd.cap_head = 1'b1;
      S_SCAN: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_addr = {q, scan};
        cmd.cap_best = scan_pend && sts.better;
      end
      S_LAST: cmd.cap_best = scan_pend && sts.better;
      S_SWAP: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_addr = {q, best_idx};
        cmd.wr_sel = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      qiu <= '0;
      for (int i = 0; i < NumQueues; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
      op <= '0; q <= '0; scan <= '0; best_idx <= '0;
      scan_pend <= 1'b0; key_time <= 1'b0;
      out_load <= 1'b0;
      out_status <= ST_OK;
      out_zero <= 1'b1;
    end else begin
      out_load <= 1'b0;
      if (cfg_we) begin
        for (int i = 0; i < NumQueues; i++) begin
          if (4'(i) >= qiu && 4'(i) < cfg_sat) begin
            head[i] <= '0;
            tail[i] <= '0;
          end
        end
        qiu <= cfg_sat;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op <= opcode;
            key_time <= (opcode == OP_MINTIME);
            out_zero <= 1'b1;
            if (opcode == OP_STRICT) begin
              q <= sq;
              out_status <= sfound ? ST_OK : ST_EMPTY;
              state <= sfound ? S_DECIDE : S_DONE;
            end else begin
              q <= queue_index;
              if (qbad) begin
                out_status <= ST_BADQ;
                state <= S_DONE;
              end else begin
                out_status <= ST_OK;
                state <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          if (op == OP_ENQ) begin
            if (PtrW'(tail[q] + 1'b1) == head[q]) out_status <= ST_FULL;
            else tail[q] <= PtrW'(tail[q] + 1'b1);
            state <= S_DONE;
          end else if (head[q] == tail[q]) begin
            out_status <= ST_EMPTY;
            state <= S_DONE;
          end else begin
            best_idx <= head[q];
            scan <= PtrW'(head[q] + 1'b1);
            scan_pend <= 1'b0;
            state <= S_RD_HEAD;
          end
        end
        S_RD_HEAD: begin
          if (op == OP_STRICT || scan == tail[q]) begin
            state <= S_SWAP;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_pend && sts.better) best_idx <= PtrW'(scan - 1'b1);
          scan_pend <= 1'b1;
          scan <= PtrW'(scan + 1'b1);
          if (PtrW'(scan + 1'b1) == tail[q]) state <= S_LAST;
        end
        S_LAST: begin
          if (sts.better) best_idx <= PtrW'(scan - 1'b1);
          state <= S_SWAP;
        end
        S_SWAP: begin
          // best slot takes the old head; the best entry leaves
          head[q] <= PtrW'(head[q] + 1'b1);
          out_zero <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          out_load <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_qiu_range: assert property (@(posedge clk) disable iff (rst)
    qiu <= 4'(NumQueues)) else $error("queue count above limit");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state != S_IDLE) else $error("accepted word left idle");
  a_swap_done: assert property (@(posedge clk) disable iff (rst)
    state == S_SWAP |=> state == S_DONE) else $error("swap not followed by done");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input open while busy");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !sts.out_busy) else $error("result written over a held word");
`endif
endmodule

@@ hdl/multilevel_ready_queue_scheduler.sv @@
`timescale 1ns / 1ps
// multilevel ready-queue scheduler
// input channel: in_valid/in_stall with opcode, queue_index and the entry
// fields; one word per operation. output channel: out_valid/out_stall with
// status and the dequeued entry (zeros unless a dequeue succeeds).
// configuration: cfg_we/cfg_data write the number of queues in use
// (saturates at eight); newly enabled queues start empty.
// path from input accept to result in the output register: a bad index or
// an empty strict dequeue goes to S_DONE; an enqueue or an empty selective
// dequeue passes S_DECIDE, S_DONE; a strict dequeue or a selective dequeue
// of one entry passes S_DECIDE, S_RD_HEAD, S_SWAP, S_DONE; for n >= 2
// entries, S_SCAN (one slot per cycle) and S_LAST come before S_SWAP.
// one word is in flight at a time; the next is taken from the cycle after the
// result is registered, once the output register is free or being drained.
// reset (rst, synchronous) empties all queues and sets queues in use to
// zero; entry memory is not cleared.
// a stalled result holds on the outputs and blocks new input words.
module multilevel_ready_queue_scheduler
  import mlrq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [3:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] opcode,
  input  logic [2:0] queue_index,
  input  logic [15:0] process_id,
  input  logic [7:0] priority_req,
  input  logic [15:0] run_time,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [15:0] out_process_id,
  output logic [7:0] out_priority,
  output logic [15:0] out_time_left
);
  cmd_t cmd;
  sts_t sts;
  logic key_time;

  mlrq_controller u_ctrl (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_stall, .opcode,
    .queue_index, .sts, .cmd, .key_time
  );

  mlrq_datapath u_dp (
    .clk, .rst, .cmd, .key_time, .process_id, .priority_req, .run_time,
    .sts, .out_valid, .out_stall, .status, .out_process_id, .out_priority,
    .out_time_left
  );
endmodule

@@ test/multilevel_ready_queue_scheduler_test.sv @@
`timescale 1ns / 1ps
module multilevel_ready_queue_scheduler_test;
  import mlrq_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] opcode;
  logic [2:0] queue_index;
  logic [15:0] process_id;
  logic [7:0] priority_req;
  logic [15:0] run_time;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic [15:0] out_process_id;
  logic [7:0] out_priority;
  logic [15:0] out_time_left;

  typedef struct packed {
    logic [1:0] st;
    entry_t ent;
  } sched_result_t;

  // scheduler shadow state
  entry_t slots [NumQueues][QueueDepth];
  int unsigned heads [NumQueues];
  int unsigned tails [NumQueues];
  int unsigned live_queues;
  sched_result_t pending_results[$];
  int errors;
  logic hold_off;
  int burst_left;

  multilevel_ready_queue_scheduler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .queue_index(queue_index), .process_id(process_id),
    .priority_req(priority_req), .run_time(run_time),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .out_process_id(out_process_id), .out_priority(out_priority),
    .out_time_left(out_time_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1) % QueueDepth;
  endfunction

  function automatic int unsigned queue_fill(int unsigned q);
    return (tails[q] + QueueDepth - heads[q]) % QueueDepth;
  endfunction

  function automatic sched_result_t schedule_op(logic [1:0] op, logic [2:0] q,
      entry_t ent);
    sched_result_t r;
    int unsigned best;
    int unsigned j;
    logic [15:0] kj;
    logic [15:0] kb;
    entry_t t;
    r = '0;
    if (op == OP_STRICT) begin
      r.st = ST_EMPTY;
      for (int i = 0; i < live_queues; i++) begin
        if (heads[i] != tails[i]) begin
          r.ent = slots[i][heads[i]];
          heads[i] = next_slot(heads[i]);
          r.st = ST_OK;
          break;
        end
      end
    end else if (q >= live_queues) begin
      r.st = ST_BADQ;
    end else if (op == OP_ENQ) begin
      if (next_slot(tails[q]) == heads[q]) begin
        r.st = ST_FULL;
      end else begin
        slots[q][tails[q]] = ent;
        tails[q] = next_slot(tails[q]);
      end
    end else if (heads[q] == tails[q]) begin
      r.st = ST_EMPTY;
    end else begin
      best = heads[q];
      j = next_slot(heads[q]);
      while (j != tails[q]) begin
        kj = (op == OP_MINTIME) ? slots[q][j].tleft : {8'd0, slots[q][j].prio};
        kb = (op == OP_MINTIME) ? slots[q][best].tleft : {8'd0, slots[q][best].prio};
        if (kj < kb) best = j;
        j = next_slot(j);
      end
      t = slots[q][heads[q]];
      slots[q][heads[q]] = slots[q][best];
      slots[q][best] = t;
      r.ent = slots[q][heads[q]];
      heads[q] = next_slot(heads[q]);
    end
    return r;
  endfunction

  // sends one word in bursts with random gaps; valid stays high inside a burst
  task automatic send_word(logic [1:0] op, logic [2:0] q, logic [15:0] pid,
      logic [7:0] pr, logic [15:0] tl);
    entry_t ent;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    opcode <= op;
    queue_index <= q;
    process_id <= pid;
    priority_req <= pr;
    run_time <= tl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ent.pid = pid;
    ent.prio = pr;
    ent.tleft = tl;
    pending_results.push_back(schedule_op(op, q, ent));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_queue_count(logic [3:0] n);
    int unsigned lim;
    drain_results();
    lim = (n > NumQueues) ? NumQueues : n;
    for (int unsigned i = live_queues; i < lim; i++) begin
      heads[i] = 0;
      tails[i] = 0;
    end
    live_queues = lim;
    cfg_data <= n;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word(int unsigned enq_weight, logic [7:0] prmax);
    logic [1:0] op;
    logic [2:0] q;
    op = ($urandom_range(0, 99) < enq_weight) ? OP_ENQ : 2'($urandom_range(1, 3));
    q = (live_queues > 0 && $urandom_range(0, 9) != 0) ?
        3'($urandom_range(0, live_queues - 1)) : 3'($urandom);
    send_word(op, q, 16'($urandom), 8'($urandom_range(0, prmax)), 16'($urandom));
  endtask

  task automatic test_directed();
    send_word(OP_STRICT, 3'd0, 16'd0, 8'd0, 16'd0);
    send_word(OP_ENQ, 3'd0, 16'hffff, 8'hff, 16'hffff);
    write_queue_count(4'd3);
    send_word(OP_ENQ, 3'd3, 16'h1, 8'h1, 16'h1);
    send_word(OP_MINPRI, 3'd7, 16'h0, 8'h0, 16'h0);
    send_word(OP_MINTIME, 3'd5, 16'h0, 8'h0, 16'h0);
    send_word(OP_MINPRI, 3'd1, 16'h0, 8'h0, 16'h0);
    send_word(OP_MINTIME, 3'd2, 16'h0, 8'h0, 16'h0);
    send_word(OP_ENQ, 3'd1, 16'hffff, 8'hff, 16'hffff);
    send_word(OP_ENQ, 3'd1, 16'h1234, 8'h05, 16'h0010);
    send_word(OP_ENQ, 3'd1, 16'h5678, 8'h05, 16'h0003);
    send_word(OP_ENQ, 3'd1, 16'h9abc, 8'h00, 16'h0003);
    send_word(OP_ENQ, 3'd2, 16'h0000, 8'h00, 16'h0000);
    // ties: first from head wins
    send_word(OP_MINTIME, 3'd1, 16'h0, 8'h0, 16'h0);
    send_word(OP_MINPRI, 3'd1, 16'h0, 8'h0, 16'h0);
    send_word(OP_STRICT, 3'd6, 16'h0, 8'h0, 16'h0);
    send_word(OP_STRICT, 3'd0, 16'h0, 8'h0, 16'h0);
    send_word(OP_STRICT, 3'd0, 16'h0, 8'h0, 16'h0);
    send_word(OP_STRICT, 3'd0, 16'h0, 8'h0, 16'h0);
    write_queue_count(4'd15);
    send_word(OP_ENQ, 3'd7, 16'h00ff, 8'h80, 16'h8000);
    send_word(OP_MINPRI, 3'd7, 16'h0, 8'h0, 16'h0);
  endtask

  task automatic test_fill_queue();
    // fill a queue to full, overflow it, dequeue from it selectively, then drain with strict dequeues
    write_queue_count(4'd2);
    for (int i = 0; i < QueueDepth + 2; i++)
      send_word(OP_ENQ, 3'd1, 16'($urandom), 8'($urandom), 16'($urandom));
    for (int i = 0; i < 20; i++)
      send_word(2'($urandom_range(2, 3)), 3'd1, 16'h0, 8'h0, 16'h0);
    for (int i = 0; i < QueueDepth; i++)
      send_word(OP_STRICT, 3'($urandom), 16'h0, 8'h0, 16'h0);
  endtask

  task automatic test_stall_pressure();
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) random_word(60, 8'hff);
    hold_off = 1'b0;
    drain_results();
  endtask

  task automatic test_random();
    logic [3:0] counts [5] = '{4'd1, 4'd8, 4'd0, 4'd5, 4'd8};
    for (int phase = 0; phase < 5; phase++) begin
      write_queue_count(counts[phase]);
      for (int i = 0; i < 240; i++)
        random_word(55, (phase % 2) ? 8'd7 : 8'hff);
    end
    // lowering keeps contents of retained queues
    write_queue_count(4'd3);
    for (int i = 0; i < 100; i++) random_word(45, 8'd3);
    drain_results();
  endtask

  // result checker
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status %0d", status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.st) begin
          $error("status expected %0d actual %0d", exp_r.st, status);
          errors++;
        end
        if (out_process_id !== exp_r.ent.pid) begin
          $error("out_process_id expected %h actual %h", exp_r.ent.pid, out_process_id);
          errors++;
        end
        if (out_priority !== exp_r.ent.prio) begin
          $error("out_priority expected %h actual %h", exp_r.ent.prio, out_priority);
          errors++;
        end
        if (out_time_left !== exp_r.ent.tleft) begin
          $error("out_time_left expected %h actual %h", exp_r.ent.tleft, out_time_left);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int held;
    out_stall = 1'b0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_off && held < 400) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        if (!hold_off) held = 0;
        out_stall <= ($urandom_range(0, 15) < 3) || ($urandom_range(0, 63) == 0);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_ENQ;
    queue_index = '0;
    process_id = '0;
    priority_req = '0;
    run_time = '0;
    hold_off = 1'b0;
    burst_left = 0;
    errors = 0;
    live_queues = 0;
    for (int i = 0; i < NumQueues; i++) begin
      heads[i] = 0;
      tails[i] = 0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_fill_queue();
    test_stall_pressure();
    test_random();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
